[sv/shadow_quad_from_block_core_assert.svh]
`ifndef SHADOW_QUAD_FROM_BLOCK_CORE_ASSERT_SVH
`define SHADOW_QUAD_FROM_BLOCK_CORE_ASSERT_SVH

// Clocked on clk_i, disabled while rst_ni is low.
`define SQB_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`define SQB_ASSERT(lbl, prop) \
  `SQB_ASSERT_MSG(lbl, prop, "shadow quad core check failed")

`endif

[sv/sqb_pkg.sv]
package sqb_pkg;

  localparam int unsigned NEAR_W    = 16;
  localparam int unsigned FAR_W     = 32;
  localparam int unsigned NUM_VTX   = 4;
  localparam int unsigned FAR_SHIFT = 15;

  typedef enum logic [0:0] {
    REG_LIGHT_X = 1'b0,
    REG_LIGHT_Y = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [NEAR_W-1:0] near_x;
    logic signed [NEAR_W-1:0] near_y;
    logic signed [FAR_W-1:0]  far_x;
    logic signed [FAR_W-1:0]  far_y;
  } vtx_t;

endpackage

[sv/sqb_blk_if.sv]
interface sqb_blk_if;
  import sqb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [NEAR_W-1:0] v0_x;
  logic signed [NEAR_W-1:0] v0_y;
  logic signed [NEAR_W-1:0] v1_x;
  logic signed [NEAR_W-1:0] v1_y;
  logic signed [NEAR_W-1:0] v2_x;
  logic signed [NEAR_W-1:0] v2_y;
  logic signed [NEAR_W-1:0] v3_x;
  logic signed [NEAR_W-1:0] v3_y;

  modport source (
    output valid, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, v3_x, v3_y,
    input  ready
  );

  modport sink (
    input  valid, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, v3_x, v3_y,
    output ready
  );
endinterface

[sv/sqb_quad_if.sv]
interface sqb_quad_if;
  import sqb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [NEAR_W-1:0] near_a_x;
  logic signed [NEAR_W-1:0] near_a_y;
  logic signed [FAR_W-1:0]  far_a_x;
  logic signed [FAR_W-1:0]  far_a_y;
  logic signed [FAR_W-1:0]  far_b_x;
  logic signed [FAR_W-1:0]  far_b_y;
  logic signed [NEAR_W-1:0] near_b_x;
  logic signed [NEAR_W-1:0] near_b_y;

  modport source (
    output valid, near_a_x, near_a_y, far_a_x, far_a_y,
           far_b_x, far_b_y, near_b_x, near_b_y,
    input  ready
  );

  modport sink (
    input  valid, near_a_x, near_a_y, far_a_x, far_a_y,
           far_b_x, far_b_y, near_b_x, near_b_y,
    output ready
  );
endinterface

[sv/shadow_quad_from_block_core.sv]
// Shadow quad behind one occluding block.
// blk_i carries one request per block: four vertices v0..v3 as signed x/y.
// quad_o returns one quad per request: near A, far A, far B, near B, where
// near A and near B are the second and third vertices ranked by squared
// distance to the light (ties keep input order) and each far point is the
// near point pushed away from the light by a gain of 32768.
// The light position is set through cfg_we_i / cfg_idx_i / cfg_wdata_i
// only while no request is in flight; the user must ensure this.
// One request per cycle is sustained while quad_o is ready. The six
// register stages (difference, magnitude and far point, squares, distance
// sums, pairwise ranking, selection) each hold one request, the first
// loaded at acceptance.
// Each stage has its own valid bit and accepts when empty or when the next
// stage moves, so a stall on quad_o backs up stage by stage and bubbles
// are filled; nothing is dropped or repeated.
// Reset clears the light to the origin and empties the pipeline.
`include "shadow_quad_from_block_core_assert.svh"

module shadow_quad_from_block_core #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  sqb_pkg::cfg_reg_e             cfg_idx_i,
  input  logic [sqb_pkg::NEAR_W-1:0]    cfg_wdata_i,
  sqb_blk_if.sink                       blk_i,
  sqb_quad_if.source                    quad_o
);
  import sqb_pkg::*;

  localparam int unsigned NST   = 6;
  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned DW    = CB + 1;
  localparam int unsigned SQW   = 2 * CB;
  localparam int unsigned DSW   = 2 * CB + 1;
  localparam int unsigned EXT_W = (CB > NEAR_W) ? CB : NEAR_W;

  function automatic logic signed [CB-1:0] to_coord(logic [NEAR_W-1:0] f);
    logic [EXT_W-1:0] e;
    e = EXT_W'(f);
    return e[CB-1:0];
  endfunction

  function automatic logic signed [NEAR_W-1:0] to_near(logic signed [CB-1:0] c);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(c);
    return e[NEAR_W-1:0];
  endfunction

  logic [NEAR_W-1:0] light_x_q, light_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x_q <= '0;
      light_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LIGHT_X: light_x_q <= cfg_wdata_i;
        REG_LIGHT_Y: light_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic signed [CB-1:0] lx, ly;
  assign lx = to_coord(light_x_q);
  assign ly = to_coord(light_y_q);

  logic [NST-1:0] vld_q;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld_q[NST-1] || quad_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign blk_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= blk_i.valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  logic [NEAR_W-1:0] in_x [NUM_VTX];
  logic [NEAR_W-1:0] in_y [NUM_VTX];

  assign in_x[0] = blk_i.v0_x;
  assign in_y[0] = blk_i.v0_y;
  assign in_x[1] = blk_i.v1_x;
  assign in_y[1] = blk_i.v1_y;
  assign in_x[2] = blk_i.v2_x;
  assign in_y[2] = blk_i.v2_y;
  assign in_x[3] = blk_i.v3_x;
  assign in_y[3] = blk_i.v3_y;

  logic signed [NEAR_W-1:0] s1_nx_q [NUM_VTX];
  logic signed [NEAR_W-1:0] s1_ny_q [NUM_VTX];
  logic signed [DW-1:0]     s1_dx_q [NUM_VTX];
  logic signed [DW-1:0]     s1_dy_q [NUM_VTX];

  vtx_t                     s2_vtx_q [NUM_VTX];
  logic [CB-1:0]            s2_ax_q  [NUM_VTX];
  logic [CB-1:0]            s2_ay_q  [NUM_VTX];

  vtx_t                     s3_vtx_q [NUM_VTX];
  logic [SQW-1:0]           s3_sx_q  [NUM_VTX];
  logic [SQW-1:0]           s3_sy_q  [NUM_VTX];

  vtx_t                     s4_vtx_q [NUM_VTX];
  logic [DSW-1:0]           s4_dist_q [NUM_VTX];

  vtx_t                     s5_vtx_q [NUM_VTX];
  logic [NUM_VTX-1:0]       s5_before_q [NUM_VTX];

  vtx_t                     out_a_q, out_b_q;

  logic [NUM_VTX-1:0] rank1, rank2;
  vtx_t               sel_a, sel_b;

  always_comb begin
    logic [2:0] cnt;
    cnt = '0;
    rank1 = '0;
    rank2 = '0;
    sel_a = '0;
    sel_b = '0;
    for (int i = 0; i < NUM_VTX; i++) begin
      cnt = '0;
      for (int j = 0; j < NUM_VTX; j++) begin
        cnt = cnt + 3'(s5_before_q[i][j]);
      end
      rank1[i] = (cnt == 3'd1);
      rank2[i] = (cnt == 3'd2);
      if (rank1[i]) sel_a = s5_vtx_q[i];
      if (rank2[i]) sel_b = s5_vtx_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_VTX; i++) begin
      if (en[0]) begin
        s1_nx_q[i] <= to_near(to_coord(in_x[i]));
        s1_ny_q[i] <= to_near(to_coord(in_y[i]));
        s1_dx_q[i] <= DW'(to_coord(in_x[i])) - DW'(lx);
        s1_dy_q[i] <= DW'(to_coord(in_y[i])) - DW'(ly);
      end
      if (en[1]) begin
        s2_vtx_q[i].near_x <= s1_nx_q[i];
        s2_vtx_q[i].near_y <= s1_ny_q[i];
        s2_vtx_q[i].far_x  <= FAR_W'(lx) + (FAR_W'(s1_dx_q[i]) << FAR_SHIFT);
        s2_vtx_q[i].far_y  <= FAR_W'(ly) + (FAR_W'(s1_dy_q[i]) << FAR_SHIFT);
        s2_ax_q[i] <= s1_dx_q[i][DW-1] ? CB'(-s1_dx_q[i]) : CB'(s1_dx_q[i]);
        s2_ay_q[i] <= s1_dy_q[i][DW-1] ? CB'(-s1_dy_q[i]) : CB'(s1_dy_q[i]);
      end
      if (en[2]) begin
        s3_vtx_q[i] <= s2_vtx_q[i];
        s3_sx_q[i]  <= SQW'(s2_ax_q[i]) * SQW'(s2_ax_q[i]);
        s3_sy_q[i]  <= SQW'(s2_ay_q[i]) * SQW'(s2_ay_q[i]);
      end
      if (en[3]) begin
        s4_vtx_q[i]  <= s3_vtx_q[i];
        s4_dist_q[i] <= DSW'(s3_sx_q[i]) + DSW'(s3_sy_q[i]);
      end
      if (en[4]) begin
        s5_vtx_q[i] <= s4_vtx_q[i];
        for (int j = 0; j < NUM_VTX; j++) begin
          if (j < i) begin
            s5_before_q[i][j] <= (s4_dist_q[j] <= s4_dist_q[i]);
          end else if (j > i) begin
            s5_before_q[i][j] <= (s4_dist_q[j] < s4_dist_q[i]);
          end else begin
            s5_before_q[i][j] <= 1'b0;
          end
        end
      end
    end
    if (en[5]) begin
      out_a_q <= sel_a;
      out_b_q <= sel_b;
    end
  end

  assign quad_o.valid    = vld_q[NST-1];
  assign quad_o.near_a_x = out_a_q.near_x;
  assign quad_o.near_a_y = out_a_q.near_y;
  assign quad_o.far_a_x  = out_a_q.far_x;
  assign quad_o.far_a_y  = out_a_q.far_y;
  assign quad_o.far_b_x  = out_b_q.far_x;
  assign quad_o.far_b_y  = out_b_q.far_y;
  assign quad_o.near_b_x = out_b_q.near_x;
  assign quad_o.near_b_y = out_b_q.near_y;

  `SQB_ASSERT(a_full_when_stalled, !blk_i.ready |-> (&vld_q))
  `SQB_ASSERT(a_accept_enters, (blk_i.valid && blk_i.ready) |=> vld_q[0])
  `SQB_ASSERT(a_rank1_onehot, vld_q[4] |-> $onehot(rank1))
  `SQB_ASSERT(a_rank2_onehot, vld_q[4] |-> ($onehot(rank2) && ((rank1 & rank2) == '0)))

endmodule
